>>> rtl/core/sorted_key_table_with_argmax_defines.svh
// Assertion macros for the sorted key table with argmax.
// Used by the top level only; needs a clock named i_clk and a reset named i_rst_n.
`ifndef SORTED_KEY_TABLE_WITH_ARGMAX_DEFINES_SVH
`define SORTED_KEY_TABLE_WITH_ARGMAX_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/skt_pkg.sv
// Shared types and constants of the sorted key table with argmax.
// No dependencies; imported by the controller, the datapath and the top level.
package skt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 27;
    localparam int MARK_W      = 16;
    localparam int POS_W       = 7;
    localparam int COUNT_W     = 7;
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 3;
    localparam int IN_W        = 56;
    localparam int OUT_W       = 56;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 3'd0,
        CMD_DELETE   = 3'd1,
        CMD_REPL_ID  = 3'd2,
        CMD_REPL_POS = 3'd3,
        CMD_FIND_ID  = 3'd4,
        CMD_READ_POS = 3'd5,
        CMD_READ_MAX = 3'd6,
        CMD_UNUSED   = 3'd7
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_BAD_POS   = 3'd3,
        ST_NO_MARK   = 3'd4,
        ST_DUP       = 3'd5
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic              marked;
        logic [MARK_W-1:0] mark;
    } t_entry;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [4:0] {
        UOP_NONE,
        UOP_LOAD,
        UOP_SRCH_INIT,
        UOP_SRCH_RD,
        UOP_SRCH_CMP,
        UOP_INS_INIT,
        UOP_INS_RD,
        UOP_INS_MOVE,
        UOP_INS_PUT,
        UOP_DEL_INIT,
        UOP_DEL_RD,
        UOP_DEL_MOVE,
        UOP_DEL_END,
        UOP_WR_FOUND,
        UOP_WR_POS,
        UOP_SCAN_INIT,
        UOP_SCAN_RD,
        UOP_SCAN_CMP,
        UOP_SHOW_RD,
        UOP_RESULT
    } t_uop;

    typedef struct packed {
        t_uop    uop;
        t_status status;
        logic    show;
    } t_ctl;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             srch_end;
        logic             hit;
        logic             ptr_zero;
        logic             id_greater;
        logic             del_end;
        logic             scan_end;
        logic             pos_bad;
        logic             best_bad;
        logic             out_free;
    } t_dp_sts;

endpackage

>>> rtl/core/sorted_key_table_with_argmax.sv
// Sorted key table with argmax tracking: up to 64 entries kept in id order.
// One command beat in on the slave stream, one result beat out on the master stream.
// Command tdata: cmd, key_id, has_mark, mark_value, position (lowest bits first).
// Result tdata: status, out_id, out_has_mark, out_mark, entry_count.
// Commands are taken one at a time; tready is high only while no command is at work.
// Lookups use a binary search, one probe read and one compare a probe, so at most 7 probes.
// Insert and delete move one entry at a time, a read and then a write, through the
// entry memory, and every changing command ends with a rescan for the best
// marked entry, one read and one compare an entry. Reads by position or of the
// maximum go from the dispatch state straight to the done state.
// Reset empties the table and forgets the best entry; no clearing pass.
// The result waits in an output register while the receiver stalls; a new
// command is accepted meanwhile, and its result is held back until the
// earlier one has been taken.
// Depends on skt_pkg, skt_ctrl, skt_dpath and the assertion macro header.
`include "sorted_key_table_with_argmax_defines.svh"

module sorted_key_table_with_argmax
    import skt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // cmd[2:0], key_id[29:3], has_mark[30], mark_value[46:31], position[53:47], zeros
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // status[2:0], out_id[29:3], out_has_mark[30], out_mark[46:31], entry_count[53:47]
    output logic [OUT_W-1:0] o_m_axis_tdata
);

    t_ctl    ctl;
    t_dp_sts sts;
    logic    start;

    assign start = i_s_axis_tvalid && o_s_axis_tready;

    // Command sequencer.
    skt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_ready (o_s_axis_tready),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    // Entry memory and working registers.
    skt_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_s_axis_tdata),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

    // A command in work blocks the next one.
    `SKT_ASSERT_NEXT(a_one_at_a_time, start, !o_s_axis_tready, "second command taken during work")
    // The count never exceeds the table depth.
    `SKT_ASSERT_SAME(a_count_range, o_m_axis_tvalid, 32'(o_m_axis_tdata[53:47]) <= TABLE_DEPTH, "entry count above depth")
    // The id and mark fields stay zero unless the status is ok.
    `SKT_ASSERT_SAME(a_zero_on_error, o_m_axis_tvalid && (o_m_axis_tdata[2:0] != ST_OK), o_m_axis_tdata[46:3] == '0, "payload on error status")

endmodule

>>> rtl/core/skt_dpath.sv
// Datapath of the sorted key table: entry memory, search, shift and scan registers,
// and the result register. Depends on skt_pkg.
module skt_dpath
    import skt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IN_W-1:0]  i_in_data,
    input  t_ctl             i_ctl,
    output t_dp_sts          o_sts,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [OUT_W-1:0] o_out_data
);

    t_entry                 mem [TABLE_DEPTH];
    t_entry                 r_rd;
    logic [CMD_W-1:0]       r_cmd;
    logic [ID_W-1:0]        r_id;
    logic                   r_flag;
    logic [MARK_W-1:0]      r_mark;
    logic [POS_W-1:0]       r_pos;
    logic [CNT_W-1:0]       r_fill;
    logic [CNT_W-1:0]       r_lo;
    logic [CNT_W-1:0]       r_hi;
    logic [ADDR_W-1:0]      r_mid;
    logic                   r_hit;
    logic [CNT_W-1:0]       r_ptr;
    logic                   r_bvalid;
    logic [ADDR_W-1:0]      r_bidx;
    logic [MARK_W-1:0]      r_bmark;
    logic [ID_W-1:0]        r_bid;
    logic                   r_ovalid;
    logic [STATUS_W-1:0]    r_ostatus;
    t_entry                 r_oent;
    logic [COUNT_W-1:0]     r_ocount;

    logic [CNT_W-1:0]       mid_full;
    logic [ADDR_W-1:0]      pos_idx;
    logic [ADDR_W-1:0]      show_idx;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    t_entry                 wr_data;
    t_entry                 new_ent;
    logic                   better;

    // Midpoint of the open search window, position index and shown entry index.
    assign mid_full = r_lo + ((r_hi - CNT_W'(1) - r_lo) >> 1);
    assign pos_idx  = ADDR_W'(r_pos - POS_W'(1));
    assign new_ent  = '{id: r_id, marked: r_flag, mark: r_mark};

    always_comb begin
        case (r_cmd)
            CMD_READ_POS: show_idx = pos_idx;
            CMD_READ_MAX: show_idx = r_bidx;
            default:      show_idx = r_mid;
        endcase
    end

    // Memory port selection for the current operation.
    always_comb begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(r_ptr);
        wr_en   = 1'b0;
        wr_addr = ADDR_W'(r_ptr);
        wr_data = r_rd;
        case (i_ctl.uop)
            UOP_SRCH_RD: rd_addr = ADDR_W'(mid_full);
            UOP_INS_RD:  rd_addr = ADDR_W'(r_ptr - CNT_W'(1));
            UOP_DEL_RD:  rd_addr = ADDR_W'(r_ptr + CNT_W'(1));
            UOP_SCAN_RD: rd_addr = ADDR_W'(r_ptr);
            UOP_SHOW_RD: rd_addr = show_idx;
            default:     rd_en   = 1'b0;
        endcase
        case (i_ctl.uop)
            UOP_INS_MOVE, UOP_DEL_MOVE: wr_en = 1'b1;
            UOP_INS_PUT: begin
                wr_en   = 1'b1;
                wr_data = new_ent;
            end
            UOP_WR_FOUND: begin
                wr_en   = 1'b1;
                wr_addr = r_mid;
                wr_data = new_ent;
            end
            UOP_WR_POS: begin
                wr_en   = 1'b1;
                wr_addr = pos_idx;
                wr_data = new_ent;
            end
            default: wr_en = 1'b0;
        endcase
    end

    // Entry memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // A marked entry wins on a higher mark, or on an equal mark and a lower id.
    assign better = r_rd.marked && (!r_bvalid || (r_rd.mark > r_bmark) ||
                    ((r_rd.mark == r_bmark) && (r_rd.id < r_bid)));

    // Command, search, shift and scan registers.
    always_ff @(posedge i_clk) begin
        case (i_ctl.uop)
            UOP_LOAD: begin
                r_cmd  <= i_in_data[2:0];
                r_id   <= i_in_data[29:3];
                r_flag <= i_in_data[30];
                r_mark <= i_in_data[46:31];
                r_pos  <= i_in_data[53:47];
            end
            UOP_SRCH_INIT: begin
                r_lo  <= '0;
                r_hi  <= r_fill;
                r_hit <= 1'b0;
            end
            UOP_SRCH_RD: r_mid <= ADDR_W'(mid_full);
            UOP_SRCH_CMP: begin
                if (r_rd.id == r_id) begin
                    r_hit <= 1'b1;
                end else if (r_id < r_rd.id) begin
                    r_hi <= CNT_W'(r_mid);
                end else begin
                    r_lo <= CNT_W'(r_mid) + CNT_W'(1);
                end
            end
            UOP_INS_INIT:  r_ptr <= r_fill;
            UOP_INS_MOVE:  r_ptr <= r_ptr - CNT_W'(1);
            UOP_DEL_INIT:  r_ptr <= CNT_W'(r_mid);
            UOP_DEL_MOVE:  r_ptr <= r_ptr + CNT_W'(1);
            UOP_SCAN_INIT: r_ptr <= '0;
            UOP_SCAN_CMP:  r_ptr <= r_ptr + CNT_W'(1);
            default: ;
        endcase
        if (i_ctl.uop == UOP_SCAN_CMP && better) begin
            r_bmark <= r_rd.mark;
            r_bid   <= r_rd.id;
        end
    end

    // Fill count and best entry index, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_bvalid <= 1'b0;
            r_bidx   <= '0;
        end else begin
            case (i_ctl.uop)
                UOP_INS_PUT: r_fill <= r_fill + CNT_W'(1);
                UOP_DEL_END: r_fill <= r_fill - CNT_W'(1);
                UOP_SCAN_INIT: begin
                    r_bvalid <= 1'b0;
                    r_bidx   <= '0;
                end
                UOP_SCAN_CMP: begin
                    if (better) begin
                        r_bvalid <= 1'b1;
                        r_bidx   <= ADDR_W'(r_ptr);
                    end
                end
                default: ;
            endcase
        end
    end

    // Result register: loaded by the controller, emptied by the receiver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_ctl.uop == UOP_RESULT) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.uop == UOP_RESULT) begin
            r_ostatus <= i_ctl.status;
            r_oent    <= i_ctl.show ? r_rd : '0;
            r_ocount  <= COUNT_W'(r_fill);
        end
    end

    // Status towards the controller.
    always_comb begin
        o_sts.cmd        = r_cmd;
        o_sts.full       = (32'(r_fill) >= TABLE_DEPTH);
        o_sts.srch_end   = r_hit || (r_lo >= r_hi);
        o_sts.hit        = r_hit;
        o_sts.ptr_zero   = (r_ptr == '0);
        o_sts.id_greater = (r_id > r_rd.id);
        o_sts.del_end    = ((r_ptr + CNT_W'(1)) >= r_fill);
        o_sts.scan_end   = (r_ptr >= r_fill);
        o_sts.pos_bad    = (r_pos == '0) || (32'(r_pos) > 32'(r_fill));
        o_sts.best_bad   = !r_bvalid || (32'(r_bidx) >= 32'(r_fill));
        o_sts.out_free   = !r_ovalid || i_out_ready;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = {2'b00, r_ocount, r_oent.mark, r_oent.marked, r_oent.id, r_ostatus};

endmodule

>>> rtl/core/skt_ctrl.sv
// Controller state machine of the sorted key table: sequences search, shift,
// rescan and result steps on the datapath. Depends on skt_pkg.
module skt_ctrl
    import skt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    output logic    o_ready,
    input  t_dp_sts i_sts,
    output t_ctl    o_ctl
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_DISP  = 13'b0000000000010,
        S_SRD   = 13'b0000000000100,
        S_SCMP  = 13'b0000000001000,
        S_IRD   = 13'b0000000010000,
        S_ICMP  = 13'b0000000100000,
        S_DRD   = 13'b0000001000000,
        S_DMV   = 13'b0000010000000,
        S_SINIT = 13'b0000100000000,
        S_CRD   = 13'b0001000000000,
        S_CCMP  = 13'b0010000000000,
        S_IPUT  = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    logic    r_show, n_show;
    t_uop    uop;

    // Next state and operation for the datapath.
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_show   = r_show;
        uop      = UOP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    uop      = UOP_LOAD;
                    n_status = ST_OK;
                    n_show   = 1'b0;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.cmd)
                    CMD_INSERT: begin
                        if (i_sts.full) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            uop     = UOP_SRCH_INIT;
                            n_state = S_SRD;
                        end
                    end
                    CMD_DELETE, CMD_REPL_ID, CMD_FIND_ID: begin
                        uop     = UOP_SRCH_INIT;
                        n_state = S_SRD;
                    end
                    CMD_REPL_POS: begin
                        if (i_sts.pos_bad) begin
                            n_status = ST_BAD_POS;
                            n_state  = S_DONE;
                        end else begin
                            uop     = UOP_WR_POS;
                            n_state = S_SINIT;
                        end
                    end
                    CMD_READ_POS: begin
                        if (i_sts.pos_bad) begin
                            n_status = ST_BAD_POS;
                        end else begin
                            uop    = UOP_SHOW_RD;
                            n_show = 1'b1;
                        end
                        n_state = S_DONE;
                    end
                    CMD_READ_MAX: begin
                        if (i_sts.best_bad) begin
                            n_status = ST_NO_MARK;
                        end else begin
                            uop    = UOP_SHOW_RD;
                            n_show = 1'b1;
                        end
                        n_state = S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            // Binary search: one probe read, then one compare.
            S_SRD: begin
                if (!i_sts.srch_end) begin
                    uop     = UOP_SRCH_RD;
                    n_state = S_SCMP;
                end else if (i_sts.cmd == CMD_INSERT) begin
                    if (i_sts.hit) begin
                        n_status = ST_DUP;
                        n_state  = S_DONE;
                    end else begin
                        uop     = UOP_INS_INIT;
                        n_state = S_IRD;
                    end
                end else if (!i_sts.hit) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else if (i_sts.cmd == CMD_DELETE) begin
                    uop     = UOP_DEL_INIT;
                    n_state = S_DRD;
                end else if (i_sts.cmd == CMD_REPL_ID) begin
                    uop     = UOP_WR_FOUND;
                    n_state = S_SINIT;
                end else begin
                    uop     = UOP_SHOW_RD;
                    n_show  = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_SCMP: begin
                uop     = UOP_SRCH_CMP;
                n_state = S_SRD;
            end
            // Insert: shift larger entries up one place from the top down.
            S_IRD: begin
                if (i_sts.ptr_zero) begin
                    n_state = S_IPUT;
                end else begin
                    uop     = UOP_INS_RD;
                    n_state = S_ICMP;
                end
            end
            S_ICMP: begin
                if (i_sts.id_greater) begin
                    n_state = S_IPUT;
                end else begin
                    uop     = UOP_INS_MOVE;
                    n_state = S_IRD;
                end
            end
            S_IPUT: begin
                uop     = UOP_INS_PUT;
                n_state = S_SINIT;
            end
            // Delete: shift the entries above the hole down one place.
            S_DRD: begin
                if (i_sts.del_end) begin
                    uop     = UOP_DEL_END;
                    n_state = S_SINIT;
                end else begin
                    uop     = UOP_DEL_RD;
                    n_state = S_DMV;
                end
            end
            S_DMV: begin
                uop     = UOP_DEL_MOVE;
                n_state = S_DRD;
            end
            // Rescan of the whole table for the best marked entry.
            S_SINIT: begin
                uop     = UOP_SCAN_INIT;
                n_state = S_CRD;
            end
            S_CRD: begin
                if (i_sts.scan_end) begin
                    n_state = S_DONE;
                end else begin
                    uop     = UOP_SCAN_RD;
                    n_state = S_CCMP;
                end
            end
            S_CCMP: begin
                uop     = UOP_SCAN_CMP;
                n_state = S_CRD;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    uop     = UOP_RESULT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
            r_show   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_show   <= n_show;
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_ctl.uop     = uop;
    assign o_ctl.status  = r_status;
    assign o_ctl.show    = r_show;

endmodule

>>> verif/tb.sv
// Self-checking testbench for the sorted key table with argmax.
// Drives command beats, predicts each result with a behavioural table model and
// checks the result stream in order. Depends on skt_pkg and the top level only.
module tb
    import skt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    // cmd, key_id, has_mark, mark_value, position (lowest bits first), zeros
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    // status, out_id, out_has_mark, out_mark, entry_count (lowest bits first)
    logic [OUT_W-1:0] m_tdata;

    sorted_key_table_with_argmax u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always #6 i_clk = ~i_clk;

    // Packed from the highest bit down, so status lands in the lowest bits.
    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [MARK_W-1:0]   mark;
        logic                marked;
        logic [ID_W-1:0]     id;
        logic [STATUS_W-1:0] status;
    } t_result;

    // Predicted table contents.
    logic [ID_W-1:0]   tbl_id   [DEPTH];
    logic              tbl_mkd  [DEPTH];
    logic [MARK_W-1:0] tbl_mark [DEPTH];
    int                tbl_fill;
    int                top_idx;
    bit                top_ok;

    t_result expected_results[$];
    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_off_cycles;
    int      errors;

    function automatic int find_slot(logic [ID_W-1:0] id);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = tbl_fill - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (id < tbl_id[mid]) hi = mid - 1;
            else if (id > tbl_id[mid]) lo = mid + 1;
            else return mid;
        end
        return -1;
    endfunction

    function automatic void rescan_top();
        top_ok = 1'b0;
        top_idx = 0;
        for (int i = 0; i < tbl_fill; i++) begin
            if (tbl_mkd[i] && (!top_ok || tbl_mark[i] > tbl_mark[top_idx] ||
                (tbl_mark[i] == tbl_mark[top_idx] && tbl_id[i] < tbl_id[top_idx]))) begin
                top_ok = 1'b1;
                top_idx = i;
            end
        end
    endfunction

    // Apply one command to the predicted table and return its result.
    function automatic t_result table_command(logic [2:0] cmd, logic [ID_W-1:0] id,
                                              logic mk, logic [MARK_W-1:0] mv, int pos);
        t_result r;
        int      f;
        int      i;
        bit      show;
        int      sel;
        r = '0;
        r.status = ST_OK;
        show = 1'b0;
        sel = 0;
        case (cmd)
            CMD_INSERT: begin
                if (tbl_fill >= DEPTH) r.status = ST_FULL;
                else if (find_slot(id) >= 0) r.status = ST_DUP;
                else begin
                    i = tbl_fill - 1;
                    while (i >= 0 && !(id > tbl_id[i])) begin
                        tbl_id[i+1] = tbl_id[i];
                        tbl_mkd[i+1] = tbl_mkd[i];
                        tbl_mark[i+1] = tbl_mark[i];
                        i--;
                    end
                    tbl_id[i+1] = id;
                    tbl_mkd[i+1] = mk;
                    tbl_mark[i+1] = mv;
                    tbl_fill++;
                    rescan_top();
                end
            end
            CMD_DELETE: begin
                f = find_slot(id);
                if (f < 0) r.status = ST_NOT_FOUND;
                else begin
                    for (int k = f; k + 1 < tbl_fill; k++) begin
                        tbl_id[k] = tbl_id[k+1];
                        tbl_mkd[k] = tbl_mkd[k+1];
                        tbl_mark[k] = tbl_mark[k+1];
                    end
                    tbl_fill--;
                    rescan_top();
                end
            end
            CMD_REPL_ID: begin
                f = find_slot(id);
                if (f < 0) r.status = ST_NOT_FOUND;
                else begin
                    tbl_id[f] = id;
                    tbl_mkd[f] = mk;
                    tbl_mark[f] = mv;
                    rescan_top();
                end
            end
            CMD_REPL_POS: begin
                if (pos < 1 || pos > tbl_fill) r.status = ST_BAD_POS;
                else begin
                    tbl_id[pos-1] = id;
                    tbl_mkd[pos-1] = mk;
                    tbl_mark[pos-1] = mv;
                    rescan_top();
                end
            end
            CMD_FIND_ID: begin
                f = find_slot(id);
                if (f < 0) r.status = ST_NOT_FOUND;
                else begin
                    show = 1'b1;
                    sel = f;
                end
            end
            CMD_READ_POS: begin
                if (pos < 1 || pos > tbl_fill) r.status = ST_BAD_POS;
                else begin
                    show = 1'b1;
                    sel = pos - 1;
                end
            end
            CMD_READ_MAX: begin
                if (!top_ok || top_idx >= tbl_fill) r.status = ST_NO_MARK;
                else begin
                    show = 1'b1;
                    sel = top_idx;
                end
            end
            default: ;
        endcase
        if (show) begin
            r.id = tbl_id[sel];
            r.marked = tbl_mkd[sel];
            r.mark = tbl_mark[sel];
        end
        r.count = COUNT_W'(tbl_fill);
        return r;
    endfunction

    // Offer one command beat, wait for acceptance and record its prediction.
    // Valid stays high after acceptance; the next call or the caller drops it.
    task automatic send_command(logic [2:0] cmd, logic [ID_W-1:0] id, logic mk,
                                logic [MARK_W-1:0] mv, logic [POS_W-1:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, pos, mv, mk, id, cmd};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        expected_results.push_back(table_command(cmd, id, mk, mv, int'(pos)));
    endtask

    // Receiver readiness: random stalls plus an optional long hold-off.
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each accepted result beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_result got;
        t_result exp_r;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = t_result'(m_tdata[53:0]);
            if (expected_results.size() == 0) begin
                $error("result beat with no command outstanding");
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (got.status !== exp_r.status) begin
                    $error("status: expected %0d, actual %0d", exp_r.status, got.status);
                    errors++;
                end
                if (got.id !== exp_r.id) begin
                    $error("out_id: expected %0d, actual %0d", exp_r.id, got.id);
                    errors++;
                end
                if (got.marked !== exp_r.marked) begin
                    $error("out_has_mark: expected %0d, actual %0d", exp_r.marked,
                           got.marked);
                    errors++;
                end
                if (got.mark !== exp_r.mark) begin
                    $error("out_mark: expected %0d, actual %0d", exp_r.mark, got.mark);
                    errors++;
                end
                if (got.count !== exp_r.count) begin
                    $error("entry_count: expected %0d, actual %0d", exp_r.count,
                           got.count);
                    errors++;
                end
                if (m_tdata[55:54] !== 2'b00) begin
                    $error("padding: expected 0, actual %0d", m_tdata[55:54]);
                    errors++;
                end
            end
        end
    end

    function automatic logic [ID_W-1:0] stored_or_new_id();
        if (tbl_fill > 0 && $urandom_range(99) < 60)
            return tbl_id[$urandom_range(tbl_fill - 1)];
        if ($urandom_range(9) == 0) return ID_W'($urandom);
        return ID_W'($urandom_range(99999999));
    endfunction

    // Corner cases: empty table, extreme ids and marks, and every error status except full.
    task automatic test_directed();
        send_command(CMD_READ_MAX, '0, 1'b0, '0, '0);
        send_command(CMD_READ_POS, '0, 1'b0, '0, 7'd0);
        send_command(CMD_DELETE, 27'd5, 1'b0, '0, '0);
        send_command(CMD_INSERT, 27'd0, 1'b0, 16'hFFFF, '0);
        send_command(CMD_READ_MAX, '0, 1'b0, '0, '0);
        send_command(CMD_INSERT, 27'h7FFFFFF, 1'b1, 16'hFFFF, 7'h7F);
        send_command(CMD_INSERT, 27'd99999999, 1'b1, 16'hFFFF, '0);
        send_command(CMD_INSERT, 27'd0, 1'b1, 16'd1, '0);
        send_command(CMD_READ_MAX, '0, 1'b0, '0, '0);
        send_command(CMD_FIND_ID, 27'h7FFFFFF, 1'b0, '0, '0);
        send_command(CMD_REPL_ID, 27'd0, 1'b1, 16'hFFFF, '0);
        send_command(CMD_READ_MAX, '0, 1'b0, '0, '0);
        send_command(CMD_REPL_POS, 27'd5, 1'b0, 16'd0, 7'd4);
        send_command(CMD_REPL_POS, 27'd5, 1'b0, 16'd0, 7'd0);
        send_command(CMD_REPL_POS, 27'h5555555, 1'b1, 16'h5555, 7'd1);
        send_command(CMD_READ_POS, '0, 1'b0, '0, 7'd3);
        send_command(CMD_READ_POS, '0, 1'b0, '0, 7'd64);
        send_command(CMD_UNUSED, 27'h2AAAAAA, 1'b1, 16'hAAAA, 7'h2A);
        send_command(CMD_DELETE, 27'h7FFFFFF, 1'b0, '0, '0);
        send_command(CMD_FIND_ID, 27'd12345, 1'b0, '0, '0);
        send_command(CMD_REPL_ID, 27'd12345, 1'b0, '0, '0);
    endtask

    // Random traffic biased to stored ids.
    task automatic test_random(int n);
        logic [2:0] cmd;
        int         pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (tbl_fill < 8 || (pick < 35 && tbl_fill < DEPTH)) cmd = CMD_INSERT;
            else if (pick < 50) cmd = CMD_DELETE;
            else if (pick < 58) cmd = CMD_REPL_ID;
            else if (pick < 64) cmd = CMD_REPL_POS;
            else if (pick < 76) cmd = CMD_FIND_ID;
            else if (pick < 86) cmd = CMD_READ_POS;
            else if (pick < 97) cmd = CMD_READ_MAX;
            else cmd = ($urandom_range(1)) ? CMD_UNUSED : CMD_INSERT;
            send_command(cmd, stored_or_new_id(), 1'($urandom),
                         ($urandom_range(3) == 0) ? 16'($urandom_range(3)) : 16'($urandom),
                         ($urandom_range(9) == 0) ? 7'($urandom)
                                                  : 7'($urandom_range(tbl_fill + 1)));
        end
    endtask

    // Fill the table to capacity and beyond to reach the full status.
    task automatic test_fill_full();
        while (tbl_fill < DEPTH)
            send_command(CMD_INSERT, ID_W'($urandom_range(99999999)), 1'($urandom),
                         16'($urandom), '0);
        send_command(CMD_INSERT, tbl_id[0], 1'b1, 16'd7, '0);
        send_command(CMD_INSERT, 27'd1, 1'b1, 16'd7, '0);
        send_command(CMD_READ_POS, '0, 1'b0, '0, 7'd64);
        send_command(CMD_READ_POS, '0, 1'b0, '0, 7'd65);
        send_command(CMD_DELETE, tbl_id[$urandom_range(DEPTH - 1)], 1'b0, '0, '0);
    endtask

    // Long receiver hold-off while commands keep coming.
    task automatic test_backpressure();
        hold_off_cycles = 600;
        send_idle_pct = 0;
        test_random(10);
    endtask

    initial begin
        int guard;
        errors = 0;
        tbl_fill = 0;
        top_idx = 0;
        top_ok = 1'b0;
        hold_off_cycles = 0;
        send_idle_pct = 24;
        recv_idle_pct = 74;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(450);
        test_fill_full();
        send_idle_pct = 74;
        recv_idle_pct = 24;
        test_random(450);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(450);
        s_tvalid <= 1'b0;
        guard = 0;
        while (expected_results.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (300) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

endmodule
